/* rtl/msp_pkg.sv */
`timescale 1ns / 1ps

package msp_pkg;

  localparam int NUM_SERVOS_DEF  = 8;
  localparam int COUNT_WIDTH_DEF = 12;

  localparam int REG_W   = 12;
  localparam int IDX_W   = 3;
  localparam int PIN_W   = 8;
  localparam int CFG_A_W = 2;
  localparam int DATA_W  = 16;

  localparam logic [CFG_A_W-1:0] REG_FRAME_PERIOD = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_WINDOW_START = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_WINDOW_END   = 2'd2;

  localparam logic [REG_W-1:0] FRAME_PERIOD_RST = 12'd3637;
  localparam logic [REG_W-1:0] WINDOW_START_RST = 12'd182;
  localparam logic [REG_W-1:0] WINDOW_END_RST   = 12'd364;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [PIN_W-1:0] ALL_PINS = 8'hFF;

endpackage

/* rtl/multi_servo_pulse_generator.sv */
`timescale 1ns / 1ps

// Pulse generator for up to eight hobby servos. Each input word is either a
// tick (in_tuser low) that advances the frame counter, or a target write
// (in_tuser high) that stores the falling-edge count of one servo. On the tick
// where the counter reaches frame_period it wraps to zero and all servo pins
// go high; on other ticks inside [window_start, window_end] each servo whose
// target matches the counter drops its pin. Every input word returns one
// output word with the pin levels after that word. The block takes one word
// per cycle unless out_tready stalls it: an input register, then the counter and
// compare bank, loading the pin and output registers. Configuration writes
// are taken at any time but must only be issued while idle.

module multi_servo_pulse_generator #(
  parameter int NUM_SERVOS  = msp_pkg::NUM_SERVOS_DEF,
  parameter int COUNT_WIDTH = msp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [2:0] servo_index, [14:3] target_tick, [15] zero
  input  logic [msp_pkg::DATA_W-1:0]  in_tdata,
  // [0] cmd
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] servo_pins
  output logic [msp_pkg::PIN_W-1:0]   out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [msp_pkg::CFG_A_W-1:0] cfg_index,
  input  logic [msp_pkg::REG_W-1:0]   cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > msp_pkg::REG_W) ? COUNT_WIDTH : msp_pkg::REG_W;
  localparam logic [msp_pkg::PIN_W-1:0] SERVO_MASK =
    msp_pkg::PIN_W'(((msp_pkg::PIN_W+1)'(1) << NUM_SERVOS) - (msp_pkg::PIN_W+1)'(1))
    & msp_pkg::ALL_PINS;

  logic [msp_pkg::REG_W-1:0] frame_period_r;
  logic [msp_pkg::REG_W-1:0] window_start_r;
  logic [msp_pkg::REG_W-1:0] window_end_r;

  logic                      s1_valid_r;
  logic                      s1_cmd_r;
  logic [msp_pkg::IDX_W-1:0] s1_idx_r;
  logic [msp_pkg::REG_W-1:0] s1_tgt_r;

  logic [COUNT_WIDTH-1:0]    frame_count_r, frame_count_nxt;
  logic [msp_pkg::PIN_W-1:0] pins_r, pins_nxt;
  logic [COUNT_WIDTH-1:0]    targets_r [NUM_SERVOS];

  logic                      out_valid_r;
  logic [msp_pkg::PIN_W-1:0] out_pins_r;

  logic                   out_free;
  logic                   s1_fire;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [CMP_W-1:0]       count_ext;
  logic                   wrap;
  logic                   in_window;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pins_r;

  assign count_inc = frame_count_r + COUNT_WIDTH'(1);
  assign count_ext = CMP_W'(count_inc);
  assign wrap      = count_ext == CMP_W'(frame_period_r);
  assign in_window = (count_ext >= CMP_W'(window_start_r)) &&
                     (count_ext <= CMP_W'(window_end_r));

  always_comb begin
    frame_count_nxt = frame_count_r;
    pins_nxt        = pins_r;
    if (s1_cmd_r == msp_pkg::CMD_TICK) begin
      if (wrap) begin
        frame_count_nxt = '0;
        pins_nxt        = pins_r | SERVO_MASK;
      end else begin
        frame_count_nxt = count_inc;
        if (in_window) begin
          for (int i = 0; i < NUM_SERVOS; i++) begin
            if (targets_r[i] == count_inc) begin
              pins_nxt[i] = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_period_r <= msp_pkg::FRAME_PERIOD_RST;
      window_start_r <= msp_pkg::WINDOW_START_RST;
      window_end_r   <= msp_pkg::WINDOW_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        msp_pkg::REG_FRAME_PERIOD: frame_period_r <= cfg_data;
        msp_pkg::REG_WINDOW_START: window_start_r <= cfg_data;
        msp_pkg::REG_WINDOW_END:   window_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r <= in_tuser;
      s1_idx_r <= in_tdata[msp_pkg::IDX_W-1:0];
      s1_tgt_r <= in_tdata[msp_pkg::IDX_W +: msp_pkg::REG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      pins_r        <= '0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        targets_r[i] <= '0;
      end
    end else if (s1_fire) begin
      frame_count_r <= frame_count_nxt;
      pins_r        <= pins_nxt;
      if (s1_cmd_r == msp_pkg::CMD_WRITE) begin
        for (int i = 0; i < NUM_SERVOS; i++) begin
          if (s1_idx_r == msp_pkg::IDX_W'(i)) begin
            targets_r[i] <= COUNT_WIDTH'(s1_tgt_r);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pins_r <= pins_nxt;
    end
  end

endmodule
